// ===== hw/rtl/circular_deque_top_assert.svh =====
// Assertion macros used by the deque RTL.
// Depends on nothing; each file that asserts includes it.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cdq_pkg.sv =====
// Types and constants shared by the circular deque.
// Depends on nothing.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH_DEF = 4;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 3;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_word;

endpackage

// ===== hw/rtl/circular_deque_top.sv =====
// Circular deque top level: input handshake, result staging, output register.
// A result is held in the pending result stage (store read data and result fields), then moved to the output register.
// Throughput: one word per cycle while the output is not stalled; the single
// read port of the store and one pending result stage set this rate.
// Reset clears indices, fill count and valid flags; the store is not cleared
// and needs no clearing pass, so words are accepted right after reset.
`timescale 1ns / 1ps

module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_pend;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      w_move;
    logic      w_take;
    t_out_word w_res;

    // move the pending result once the output register frees up
    assign w_move     = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !w_move;
    assign w_take     = i_in_valid && !o_in_stall;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_word  (i_in_word),
        .o_res   (w_res)
    );

    // track pending and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the output word
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/cdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cdq_ctrl.sv =====
// Deque control: head/tail indices, fill count and the word store.
// Depends on cdq_pkg, cdq_ram and circular_deque_top_assert.svh.
`timescale 1ns / 1ps
`include "circular_deque_top_assert.svh"

module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_word  i_word,
    output t_out_word o_res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = CNT_W + OCC_W;

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic              w_re;
    logic [IDX_W-1:0]  w_raddr;
    logic [STAT_W-1:0] w_status;
    logic              w_pop_ok;
    logic              w_is_push;
    logic              w_full;
    logic              w_empty;
    logic [EXT_W-1:0]  w_occ_ext;
    logic [WORD_W-1:0] w_rdata;

    logic              r_res_pop;
    logic [STAT_W-1:0] r_res_status;
    logic [OCC_W-1:0]  r_res_occ;

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        next_pos = (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] prev_pos(input logic [IDX_W-1:0] p);
        prev_pos = (p == '0) ? IDX_W'(DEPTH - 1) : p - IDX_W'(1);
    endfunction

    assign w_is_push = i_word.mode inside {MODE_PUSH_REAR, MODE_PUSH_FRONT};
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);

    // decode the operation into index updates and store accesses
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_re     = 1'b0;
        w_raddr  = r_head;
        w_status = STAT_OK;
        w_pop_ok = 1'b0;
        if (w_is_push) begin
            if (w_full) begin
                w_status = STAT_FULL;
            end else if (w_empty) begin
                n_head  = '0;
                n_tail  = '0;
                n_count = CNT_W'(1);
                w_we    = i_take;
                w_waddr = '0;
            end else if (i_word.mode == MODE_PUSH_REAR) begin
                n_tail  = next_pos(r_tail);
                n_count = r_count + CNT_W'(1);
                w_we    = i_take;
                w_waddr = n_tail;
            end else begin
                n_head  = prev_pos(r_head);
                n_count = r_count + CNT_W'(1);
                w_we    = i_take;
                w_waddr = n_head;
            end
        end else begin
            if (w_empty) begin
                w_status = STAT_EMPTY;
            end else begin
                w_re     = i_take;
                w_pop_ok = 1'b1;
                n_count  = r_count - CNT_W'(1);
                if (i_word.mode == MODE_POP_FRONT) begin
                    w_raddr = r_head;
                    n_head  = next_pos(r_head);
                end else begin
                    w_raddr = r_tail;
                    n_tail  = prev_pos(r_tail);
                end
                // last word gone: return both indices to the origin
                if (r_count == CNT_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
            end
        end
    end

    assign w_occ_ext = EXT_W'(n_count);

    // advance indices and count on each taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // hold result fields alongside the store read
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_res_pop    <= w_pop_ok;
            r_res_status <= w_status;
            r_res_occ    <= w_occ_ext[OCC_W-1:0];
        end
    end

    cdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_word.push_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_res.popped_value = r_res_pop ? signed'(w_rdata) : '0;
    assign o_res.status       = r_res_status;
    assign o_res.occupancy    = r_res_occ;

    `CDQ_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    `CDQ_ASSERT_NOW(a_empty_origin, i_clk, i_rst_n, r_count == '0, r_head == '0 && r_tail == '0, "empty deque with indices off origin")
    `CDQ_ASSERT_NEXT(a_refused_hold, i_clk, i_rst_n, i_take && w_status != STAT_OK, $stable(r_count) && $stable(r_head) && $stable(r_tail), "refused operation changed state")
    `CDQ_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, i_take && w_pop_ok, r_count == $past(r_count) - CNT_W'(1), "pop did not drop count")

endmodule
